// ===== rtl/sird_pkg.sv =====
`timescale 1ns / 1ps
package sird_pkg;

  localparam int NUM_W      = 32;
  localparam int RADIX_W    = 5;
  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 8;
  localparam int TOTAL_W    = 6;
  localparam int ALPHA_CHARS = 16;
  localparam int ALPHA_W    = ALPHA_CHARS * CHAR_W;
  localparam int DIG_DEPTH  = 32;
  localparam int DIG_AW     = $clog2(DIG_DEPTH);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // reciprocal scaled by 2^RECIP_SHIFT, floor
  localparam int RECIP_SHIFT = 35;
  localparam int RECIP_W     = 35;
  localparam int PROD_W      = NUM_W + RECIP_W;

  localparam logic [CHAR_W-1:0] MINUS_CODE = 8'h2D;
  localparam logic [CHAR_W-1:0] PLUS_CODE  = 8'h2B;
  localparam logic [CHAR_W-1:0] PRINT_LO   = 8'h20;
  localparam logic [CHAR_W-1:0] PRINT_HI   = 8'h7E;
  localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIX_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LO  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HI  = 2'd2;

  typedef struct packed {
    logic                  done;
    logic [NUM_W-1:0]      quo;
    logic [DIGIT_W-1:0]    rem;
  } div_res_t;

  function automatic logic [RECIP_W-1:0] recip_lookup(input logic [RADIX_W-1:0] r);
    logic [RECIP_W-1:0] m;
    case (r)
      5'd2:    m = 35'd17179869184;
      5'd3:    m = 35'd11453246122;
      5'd4:    m = 35'd8589934592;
      5'd5:    m = 35'd6871947673;
      5'd6:    m = 35'd5726623061;
      5'd7:    m = 35'd4908534052;
      5'd8:    m = 35'd4294967296;
      5'd9:    m = 35'd3817748707;
      5'd10:   m = 35'd3435973836;
      5'd11:   m = 35'd3123612578;
      5'd12:   m = 35'd2863311530;
      5'd13:   m = 35'd2643056797;
      5'd14:   m = 35'd2454267026;
      5'd15:   m = 35'd2290649224;
      5'd16:   m = 35'd2147483648;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/signed_int_to_radix_digits.sv =====
`timescale 1ns / 1ps
// Writes a signed 32-bit integer out as ASCII characters in a configured radix.
// Configuration: cfg_index 0 sets the radix (alphabet length), 1 and 2 load
// alphabet characters 0..7 and 8..15, lowest byte first. cfg_ready is always
// high; write only while no item is in flight.
// Input: one item per in_valid/in_ready handshake; in_ready is high only while
// the block is idle. Output: one item per character, most significant digit
// first, a leading minus for negative values. is_last marks the final item of
// an input, which also carries emitted_total. A bad alphabet gives a single
// item with alphabet_bad set.
// Timing: each digit passes through the shared reciprocal divider, first its
// product register and then its quotient and remainder register; the characters
// then follow at one per cycle while the receiver is ready.
// A stalled receiver holds the output register and the sequencer waits; the
// next input is taken as soon as the last character is registered.
// Reset (synchronous, rst_n low) clears the configuration, the output valid flag
// and the digit count and idles the block; the data registers are not reset.
module signed_int_to_radix_digits
  import sird_pkg::*;
#(
  parameter int MAX_RADIX = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [NUM_W-1:0] in_number,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CHAR_W-1:0]     out_char_code,
  output logic                  out_is_last,
  output logic                  out_alphabet_bad,
  output logic [TOTAL_W-1:0]    out_emitted_total
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_WAIT, S_EMIT} state_t;

  state_t                state_r;
  logic [RADIX_W-1:0]    radix_len_r;
  logic [CFG_DATA_W-1:0] alpha_lo_r;
  logic [CFG_DATA_W-1:0] alpha_hi_r;
  logic [NUM_W-1:0]      mag_r;
  logic                  neg_r;
  logic                  bad_r;
  logic                  sign_pend_r;
  logic [TOTAL_W-1:0]    nd_r;
  logic [TOTAL_W-1:0]    tot_r;
  logic [DIGIT_W-1:0]    rd_digit_r;
  logic [DIGIT_W-1:0]    dig_mem [DIG_DEPTH];

  logic                  out_valid_r;
  logic [CHAR_W-1:0]     out_char_r;
  logic                  out_last_r;
  logic                  out_bad_r;
  logic [TOTAL_W-1:0]    out_total_r;

  logic [ALPHA_W-1:0]    alphabet;
  logic                  alpha_bad;
  logic                  slot_free;
  logic                  more_digits;
  logic                  div_start;
  logic [NUM_W-1:0]      div_dividend;
  div_res_t              div_res;
  logic [CHAR_W-1:0]     digit_char;
  logic [NUM_W-1:0]      in_raw;

  assign alphabet  = {alpha_hi_r, alpha_lo_r};
  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign slot_free = !out_valid_r || out_ready;
  assign in_raw    = in_number;

  sird_alpha_check #(
    .MAX_RADIX (MAX_RADIX)
  ) u_check (
    .radix_len (radix_len_r),
    .alphabet  (alphabet),
    .alpha_bad (alpha_bad)
  );

  // chain the next division straight off the previous quotient
  assign more_digits  = (div_res.quo != '0) && (nd_r != TOTAL_W'(DIG_DEPTH - 1));
  assign div_start    = (state_r == S_DIV) ||
                        ((state_r == S_WAIT) && div_res.done && more_digits);
  assign div_dividend = (state_r == S_DIV) ? mag_r : div_res.quo;

  sird_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .radix    (radix_len_r),
    .res      (div_res)
  );

  assign digit_char = alphabet[{rd_digit_r, 3'b000} +: CHAR_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_len_r <= '0;
      alpha_lo_r  <= '0;
      alpha_hi_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RADIX_LEN: radix_len_r <= cfg_data[RADIX_W-1:0];
        CFG_ALPHA_LO:  alpha_lo_r  <= cfg_data;
        CFG_ALPHA_HI:  alpha_hi_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sign_pend_r <= 1'b0;
      nd_r        <= '0;
    end else begin
      // while emitting, the emit arm below decides the output valid
      if (out_valid_r && out_ready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            neg_r   <= in_raw[NUM_W-1];
            mag_r   <= in_raw[NUM_W-1] ? (NUM_W'(0) - in_raw) : in_raw;
            bad_r   <= alpha_bad;
            nd_r    <= '0;
            state_r <= alpha_bad ? S_EMIT : S_DIV;
          end
        end
        S_DIV: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (div_res.done) begin
            dig_mem[nd_r[DIG_AW-1:0]] <= div_res.rem;
            // newest digit is the first one read out
            rd_digit_r <= div_res.rem;
            nd_r <= nd_r + TOTAL_W'(1);
            if (!more_digits) begin
              tot_r       <= nd_r + TOTAL_W'(1) + TOTAL_W'(neg_r);
              sign_pend_r <= neg_r;
              state_r     <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            if (bad_r) begin
              out_char_r  <= '0;
              out_last_r  <= 1'b1;
              out_bad_r   <= 1'b1;
              out_total_r <= '0;
              state_r     <= S_IDLE;
            end else if (sign_pend_r) begin
              // at least one digit always follows the sign
              out_char_r  <= MINUS_CODE;
              out_last_r  <= 1'b0;
              out_bad_r   <= 1'b0;
              out_total_r <= '0;
              sign_pend_r <= 1'b0;
            end else begin
              out_char_r  <= digit_char;
              out_last_r  <= (nd_r == TOTAL_W'(1));
              out_bad_r   <= 1'b0;
              out_total_r <= (nd_r == TOTAL_W'(1)) ? tot_r : '0;
              nd_r        <= nd_r - TOTAL_W'(1);
              // fetch the digit for the next character
              rd_digit_r  <= dig_mem[DIG_AW'(nd_r - TOTAL_W'(2))];
              if (nd_r == TOTAL_W'(1)) begin
                state_r <= S_IDLE;
              end
            end
          end else begin
            out_valid_r <= out_valid_r;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_char_code     = out_char_r;
  assign out_is_last       = out_last_r;
  assign out_alphabet_bad  = out_bad_r;
  assign out_emitted_total = out_total_r;

endmodule

// ===== rtl/sird_alpha_check.sv =====
`timescale 1ns / 1ps
module sird_alpha_check
  import sird_pkg::*;
#(
  parameter int MAX_RADIX = 16
) (
  input  logic [RADIX_W-1:0] radix_len,
  input  logic [ALPHA_W-1:0] alphabet,
  output logic               alpha_bad
);

  logic [ALPHA_CHARS-1:0] in_use;
  logic [ALPHA_CHARS-1:0] char_bad;
  logic [ALPHA_CHARS-1:0] dup_hit;
  logic                   len_bad;

  assign len_bad = (radix_len < MIN_RADIX) || (radix_len > RADIX_W'(MAX_RADIX));

  always_comb begin
    for (int i = 0; i < ALPHA_CHARS; i++) begin
      logic [CHAR_W-1:0] c;
      c = alphabet[i*CHAR_W +: CHAR_W];
      in_use[i]   = radix_len > RADIX_W'(i);
      char_bad[i] = in_use[i] && ((c == MINUS_CODE) || (c == PLUS_CODE) ||
                                  (c < PRINT_LO) || (c > PRINT_HI));
      dup_hit[i]  = 1'b0;
      // pairwise compare against every later character in use
      for (int j = i + 1; j < ALPHA_CHARS; j++) begin
        if (in_use[i] && (radix_len > RADIX_W'(j)) &&
            (alphabet[j*CHAR_W +: CHAR_W] == c)) begin
          dup_hit[i] = 1'b1;
        end
      end
    end
  end

  assign alpha_bad = len_bad || (|char_bad) || (|dup_hit);

endmodule

// ===== rtl/sird_divider.sv =====
`timescale 1ns / 1ps
module sird_divider
  import sird_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [NUM_W-1:0]   dividend,
  input  logic [RADIX_W-1:0] radix,
  output div_res_t           res
);

  logic                  busy_r;
  logic                  done_r;
  logic [PROD_W-1:0]     prod_r;
  logic [NUM_W-1:0]      dvd_r;
  logic [RADIX_W-1:0]    radix_r;
  logic [NUM_W-1:0]      quo_r;
  logic [DIGIT_W-1:0]    rem_r;

  logic [NUM_W-1:0]      q_est;
  logic [5:0]            qr_low;
  logic [5:0]            rem6;
  logic [5:0]            rem6_adj;
  logic                  fix;
  logic [NUM_W-1:0]      quo_nxt;
  logic [DIGIT_W-1:0]    rem_nxt;

  // floor reciprocal is at most one short, so only the low bits of q*r matter
  assign q_est    = prod_r[PROD_W-1:RECIP_SHIFT];
  assign qr_low   = 6'(q_est[5:0] * {1'b0, radix_r});
  assign rem6     = dvd_r[5:0] - qr_low;
  assign fix      = rem6 >= {1'b0, radix_r};
  assign rem6_adj = rem6 - {1'b0, radix_r};
  assign quo_nxt  = fix ? q_est + NUM_W'(1) : q_est;
  assign rem_nxt  = fix ? rem6_adj[DIGIT_W-1:0] : rem6[DIGIT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= start;
      done_r <= busy_r;
      if (start) begin
        prod_r  <= PROD_W'(dividend) * PROD_W'(recip_lookup(radix));
        dvd_r   <= dividend;
        radix_r <= radix;
      end
      if (busy_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
      end
    end
  end

  assign res.done = done_r;
  assign res.quo  = quo_r;
  assign res.rem  = rem_r;

endmodule

// ===== test/sird_char_checker.sv =====
`timescale 1ns / 1ps
module sird_char_checker
  import sird_pkg::*;
#(
  parameter int MAX_RADIX = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic signed [NUM_W-1:0] in_number,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [CHAR_W-1:0]       out_char_code,
  input  logic                    out_is_last,
  input  logic                    out_alphabet_bad,
  input  logic [TOTAL_W-1:0]      out_emitted_total,
  output int                      mismatch_count,
  output int                      chars_pending
);

  typedef struct packed {
    logic [CHAR_W-1:0]  char_code;
    logic               is_last;
    logic               alphabet_bad;
    logic [TOTAL_W-1:0] emitted_total;
  } char_item_t;

  char_item_t            expected_chars [$];
  logic [RADIX_W-1:0]    radix_reg;
  logic [CFG_DATA_W-1:0] alpha_lo_reg;
  logic [CFG_DATA_W-1:0] alpha_hi_reg;
  int                    mismatch_total = 0;

  assign mismatch_count = mismatch_total;

  function automatic logic [CHAR_W-1:0] alpha_char(input int k);
    if (k < 8) return alpha_lo_reg[8*k +: CHAR_W];
    return alpha_hi_reg[8*(k-8) +: CHAR_W];
  endfunction

  function automatic bit alphabet_ok();
    logic [CHAR_W-1:0] c;
    if (radix_reg < MIN_RADIX || radix_reg > MAX_RADIX || radix_reg > ALPHA_CHARS) return 1'b0;
    for (int i = 0; i < radix_reg; i++) begin
      c = alpha_char(i);
      if (c == MINUS_CODE || c == PLUS_CODE || c < PRINT_LO || c > PRINT_HI) return 1'b0;
      for (int j = i + 1; j < radix_reg; j++)
        if (alpha_char(j) == c) return 1'b0;
    end
    return 1'b1;
  endfunction

  // expected characters of one number, most significant digit first
  task automatic predict_chars(input logic signed [NUM_W-1:0] number);
    logic [NUM_W-1:0]   mag;
    logic [DIGIT_W-1:0] digits [$];
    bit                 neg;
    int                 total;
    int                 k;
    char_item_t         item;
    if (!alphabet_ok()) begin
      item = '{char_code: '0, is_last: 1'b1, alphabet_bad: 1'b1, emitted_total: '0};
      expected_chars.push_back(item);
      return;
    end
    neg = number[NUM_W-1];
    mag = number;
    if (neg) mag = -mag;
    do begin
      digits.push_front(DIGIT_W'(mag % radix_reg));
      mag = mag / radix_reg;
    end while (mag != 0 && digits.size() < DIG_DEPTH);
    total = digits.size() + (neg ? 1 : 0);
    k = 0;
    if (neg) begin
      item = '{char_code: MINUS_CODE, is_last: total == 1, alphabet_bad: 1'b0,
               emitted_total: (total == 1) ? TOTAL_W'(total) : '0};
      expected_chars.push_back(item);
      k++;
    end
    foreach (digits[i]) begin
      item = '{char_code: alpha_char(digits[i]), is_last: k + 1 == total, alphabet_bad: 1'b0,
               emitted_total: (k + 1 == total) ? TOTAL_W'(total) : '0};
      expected_chars.push_back(item);
      k++;
    end
  endtask

  task automatic check_field(input string field, input int expected, input int actual);
    if (expected != actual) begin
      mismatch_total++;
      $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h", $time, field, expected,
               actual);
    end
  endtask

  always @(posedge clk) begin
    char_item_t want;
    if (!rst_n) begin
      radix_reg    = '0;
      alpha_lo_reg = '0;
      alpha_hi_reg = '0;
      expected_chars.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RADIX_LEN: radix_reg    = cfg_data[RADIX_W-1:0];
          CFG_ALPHA_LO:  alpha_lo_reg = cfg_data;
          CFG_ALPHA_HI:  alpha_hi_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_chars(in_number);
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          mismatch_total++;
          $display("%0t: output item with none expected, expected nothing, actual char 'h%0h",
                   $time, out_char_code);
        end else begin
          want = expected_chars.pop_front();
          // char code carries no meaning when the alphabet is rejected
          if (!want.alphabet_bad) check_field("char_code", want.char_code, out_char_code);
          check_field("is_last", want.is_last, out_is_last);
          check_field("alphabet_bad", want.alphabet_bad, out_alphabet_bad);
          check_field("emitted_total", want.emitted_total, out_emitted_total);
        end
      end
    end
    chars_pending <= expected_chars.size();
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top
  import sird_pkg::*;
();

  localparam int MAX_RADIX    = 16;
  localparam int RANDOM_ITEMS = 180;
  localparam int QUIET_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 120;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

  // "0123456789ABCDEF", lowest byte first
  localparam logic [CFG_DATA_W-1:0] DIGITS_LO = 64'h3736353433323130;
  localparam logic [CFG_DATA_W-1:0] DIGITS_HI = 64'h4645444342413938;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [NUM_W-1:0] in_number;
  logic                    out_valid;
  logic                    out_ready;
  logic [CHAR_W-1:0]       out_char_code;
  logic                    out_is_last;
  logic                    out_alphabet_bad;
  logic [TOTAL_W-1:0]      out_emitted_total;
  int                      mismatch_count;
  int                      chars_pending;
  int                      quiet_cycles;
  bit                      steady_run;

  signed_int_to_radix_digits #(.MAX_RADIX(MAX_RADIX)) dut (.*);

  sird_char_checker #(.MAX_RADIX(MAX_RADIX)) u_checker (.*);

  always #4 clk = ~clk;

  always @(posedge clk)
    out_ready <= steady_run ? 1'b1 : ($urandom_range(0, 99) >= 33);

  // nothing accepted on any channel for too long means a hang
  always @(posedge clk) begin
    if (!rst_n || (cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_config(input logic [CFG_DATA_W-1:0] len_word, lo, hi);
    write_reg(CFG_RADIX_LEN, len_word);
    write_reg(CFG_ALPHA_LO, lo);
    write_reg(CFG_ALPHA_HI, hi);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_number(input logic signed [NUM_W-1:0] value);
    while (!steady_run && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_number <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
  endtask

  task automatic rejected_alphabet(input logic [CFG_DATA_W-1:0] len_word, lo, hi);
    apply_config(len_word, lo, hi);
    send_number(32'sd1);
    wait_drained();
  endtask

  task automatic random_alphabet();
    logic [CHAR_W-1:0]     chars [ALPHA_CHARS];
    logic [CHAR_W-1:0]     pool [$];
    logic [RADIX_W-1:0]    len;
    logic [CFG_DATA_W-1:0] len_word;
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    int                    used;
    int                    slot;
    for (int k = 0; k < ALPHA_CHARS; k++) chars[k] = CHAR_W'($urandom_range(0, 255));
    for (int k = PRINT_LO; k <= PRINT_HI; k++)
      if (k != MINUS_CODE && k != PLUS_CODE) pool.push_back(CHAR_W'(k));
    len = ($urandom_range(0, 99) < 85) ? RADIX_W'($urandom_range(MIN_RADIX, MAX_RADIX))
                                       : RADIX_W'($urandom_range(0, 31));
    used = (len > ALPHA_CHARS) ? ALPHA_CHARS : len;
    for (int k = 0; k < used; k++) begin
      slot = $urandom_range(0, pool.size() - 1);
      chars[k] = pool[slot];
      pool.delete(slot);
    end
    // now and then spoil one character inside the used part
    if (used >= 2 && $urandom_range(0, 99) < 20) begin
      slot = $urandom_range(0, used - 1);
      case ($urandom_range(0, 3))
        0: chars[slot] = MINUS_CODE;
        1: chars[slot] = PLUS_CODE;
        2: chars[slot] = $urandom_range(0, 1) ? CHAR_W'($urandom_range(0, PRINT_LO - 1))
                                             : CHAR_W'($urandom_range(PRINT_HI + 1, 255));
        default: chars[slot] = chars[(slot + 1) % used];
      endcase
    end
    for (int k = 0; k < 8; k++) begin
      lo[8*k +: CHAR_W] = chars[k];
      hi[8*k +: CHAR_W] = chars[k+8];
    end
    len_word = {$urandom, $urandom};
    len_word[RADIX_W-1:0] = len;
    apply_config(len_word, lo, hi);
  endtask

  function automatic logic signed [NUM_W-1:0] random_number();
    case ($urandom_range(0, 4))
      0, 1: return $urandom;
      2: return $urandom_range(0, 300);
      3: return -$signed(NUM_W'($urandom_range(1, 300)));
      default: return $urandom_range(0, 1) ? 32'sh80000000 : 32'sh7FFFFFFF;
    endcase
  endfunction

  initial begin
    int sent;
    int burst;
    rst_n      <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    in_number  <= '0;
    steady_run <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty alphabet out of reset
    send_number(32'sd0);
    send_number(-32'sd1);
    wait_drained();

    // decimal, plus a write to the unused index that must change nothing
    apply_config(64'd10, DIGITS_LO, DIGITS_HI);
    write_reg(CFG_NONE, '1);
    cfg_valid <= 1'b0;
    send_number(32'sd0);
    send_number(32'sd1);
    send_number(-32'sd1);
    send_number(32'sh7FFFFFFF);
    send_number(32'sh80000000);
    send_number(32'sd1000);
    send_number(-32'sd909);
    wait_drained();

    // binary, high bits of the length word and minus signs past the end are ignored
    apply_config(64'hFFFFFFFFFFFFFFE2, 64'h2D2D2D2D2D2D3130, DIGITS_HI);
    send_number(32'sh80000000);
    send_number(32'sh7FFFFFFF);
    send_number(32'sd0);
    wait_drained();

    // widest radix
    apply_config(64'd16, DIGITS_LO, DIGITS_HI);
    send_number(32'sh80000000);
    send_number(-32'sd1);
    send_number(32'shDEADBEEF);
    wait_drained();

    // alphabets that must be refused
    rejected_alphabet(64'd10, 64'h373635342D323130, DIGITS_HI);
    rejected_alphabet(64'd10, DIGITS_LO, 64'h4645444342412B38);
    rejected_alphabet(64'd10, 64'h373635343332311F, DIGITS_HI);
    rejected_alphabet(64'd10, DIGITS_LO, 64'h464544434241397F);
    rejected_alphabet(64'd10, 64'h3736313433323130, DIGITS_HI);
    rejected_alphabet(64'd1, DIGITS_LO, DIGITS_HI);
    rejected_alphabet(64'd17, DIGITS_LO, DIGITS_HI);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      random_alphabet();
      burst = $urandom_range(4, 16);
      for (int i = 0; i < burst; i++) begin
        // a long run with both sides always ready
        steady_run <= (sent >= 60 && sent < 100);
        send_number(random_number());
        sent++;
      end
      wait_drained();
    end
    steady_run <= 1'b0;

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && chars_pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
